[hw/rtl/rlrf_pkg.sv]
// Shared types, constants and the luminance key function for the
// RGB luminance rank filter. No dependencies.
package rlrf_pkg;

  localparam int KEY_W = 8;
  localparam int QDEPTH = 8;
  localparam int QAW = 3;
  localparam logic [19:0] KEY_MUL = 20'd683;
  localparam int KEY_SHIFT = 11;

  typedef enum logic [1:0] {
    REG_RADIUS       = 2'd0,
    REG_RANK_INDEX   = 2'd1,
    REG_LINE_WIDTH   = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } meta_t;

  typedef struct packed {
    pixel_t pix;
    meta_t  meta;
  } result_t;

  // effective geometry, derived from the config registers
  typedef struct packed {
    logic [3:0]  r;
    logic [3:0]  side;
    logic [10:0] w;
    logic [10:0] h;
  } geom_t;

  // (R+G+B)/3 as multiply by reciprocal; exact for sums up to 765
  function automatic logic [KEY_W-1:0] luma_key(input pixel_t p);
    logic [9:0]  s;
    logic [19:0] m;
    s = 10'(p.red) + 10'(p.green) + 10'(p.blue);
    m = 20'(s) * KEY_MUL;
    return m[KEY_SHIFT+KEY_W-1:KEY_SHIFT];
  endfunction

endpackage

[hw/rtl/rlrf_front.sv]
// Front end: position counters, line store banks and the sliding window.
// Depends on rlrf_pkg.
module rlrf_front import rlrf_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int WIN = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  pixel_t           px,
  input  logic             frame_start,
  input  geom_t            geom,
  output pixel_t           win_pix [WIN*WIN],
  output logic [KEY_W-1:0] win_key [WIN*WIN],
  output logic             win_valid,
  output meta_t            win_meta,
  output logic [1:0]       busy
);

  localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int BW = (WIN > 1) ? $clog2(WIN) : 1;

  logic [10:0]   col_count, col_next;
  logic [9:0]    row_count, row_next;
  logic [BW-1:0] row_bank, row_bank_next;

  logic [10:0]   col_cur;
  logic [9:0]    row_cur;
  logic [BW-1:0] bank_cur;
  logic [10:0]   side_m1;
  logic          emit;
  meta_t         meta_cur;
  logic [10:0]   row_ofs, col_ofs;

  pixel_t        rdata [WIN];
  logic          f1_valid, f1_emit;
  pixel_t        f1_px;
  logic [BW-1:0] f1_bank;
  meta_t         f1_meta;
  pixel_t        col_vec [WIN];

  always_comb begin
    col_cur  = frame_start ? 11'd0 : col_count;
    row_cur  = frame_start ? 10'd0 : row_count;
    bank_cur = frame_start ? '0 : row_bank;
    side_m1  = 11'(geom.side) - 11'd1;
    emit = ({1'b0, row_cur} < geom.h) && (col_cur < geom.w) &&
           ({1'b0, row_cur} >= side_m1) && (col_cur >= side_m1);
    row_ofs = {1'b0, row_cur} - 11'(geom.r) + 11'd1;
    col_ofs = col_cur - 11'(geom.r) + 11'd1;
    meta_cur.row  = row_ofs[9:0];
    meta_cur.col  = col_ofs[9:0];
    meta_cur.last = ({1'b0, row_cur} == geom.h - 11'd1) && (col_cur == geom.w - 11'd1);
    col_next      = col_cur + 11'd1;
    row_next      = row_cur;
    row_bank_next = bank_cur;
    if (col_cur + 11'd1 >= geom.w) begin
      col_next = 11'd0;
      if ({1'b0, row_cur} + 11'd1 >= geom.h) begin
        row_next      = 10'd0;
        row_bank_next = '0;
      end else begin
        row_next      = row_cur + 10'd1;
        row_bank_next = (32'(bank_cur) == WIN - 1) ? '0 : bank_cur + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= 11'd0;
      row_count <= 10'd0;
      row_bank  <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
      row_bank  <= row_bank_next;
    end
  end

  // one line store bank per window row, ring-indexed by row mod WIN
  for (genvar g = 0; g < WIN; g++) begin : g_bank
    pixel_t mem [MAX_LINE_WIDTH];
    always_ff @(posedge clk) begin
      if (accept && bank_cur == BW'(g)) begin
        mem[AW'(col_cur)] <= px;
      end
      if (accept) begin
        rdata[g] <= mem[AW'(col_cur)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
    f1_emit <= emit;
    f1_px   <= px;
    f1_bank <= bank_cur;
    f1_meta <= meta_cur;
  end

  // age k row lives in bank (bank - k) mod WIN; age 0 is the new pixel
  always_comb begin
    logic [BW:0] t;
    t = '0;
    for (int k = 0; k < WIN; k++) begin
      t = {1'b0, f1_bank} + (BW+1)'(WIN - k);
      if (t >= (BW+1)'(WIN)) begin
        t = t - (BW+1)'(WIN);
      end
      col_vec[k] = (k == 0) ? f1_px : rdata[t[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else begin
      win_valid <= f1_valid && f1_emit;
    end
    if (f1_valid) begin
      win_meta <= f1_meta;
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          if (j == 0) begin
            win_pix[i*WIN] <= col_vec[i];
            win_key[i*WIN] <= luma_key(col_vec[i]);
          end else begin
            win_pix[i*WIN+j] <= win_pix[i*WIN+j-1];
            win_key[i*WIN+j] <= win_key[i*WIN+j-1];
          end
        end
      end
    end
  end

  assign busy = 2'(f1_valid && f1_emit) + 2'(win_valid);

endmodule

[hw/rtl/rlrf_rank.sv]
// Back end: rank of every window cell by key with raster tie-break, then
// selection of the cell at the requested rank. Depends on rlrf_pkg.
module rlrf_rank import rlrf_pkg::*; #(
  parameter int WIN = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pixel_t           pix [WIN*WIN],
  input  logic [KEY_W-1:0] key [WIN*WIN],
  input  meta_t            meta,
  input  logic [3:0]       side,
  input  logic [5:0]       idx,
  output logic             res_valid,
  output result_t          res,
  output logic [1:0]       busy
);

  localparam int CELLS = WIN * WIN;
  localparam int GW = $clog2(WIN + 1);
  localparam int RKW = $clog2(CELLS + 1);

  logic          act [CELLS];
  logic [GW-1:0] cnt [CELLS][WIN];
  logic [GW-1:0] s2_cnt [CELLS][WIN];
  logic          s2_act [CELLS];
  pixel_t        s2_pix [CELLS];
  meta_t         s2_meta;
  logic          s2_valid;
  logic [RKW-1:0] rank [CELLS];
  logic          hit [CELLS];
  logic          s3_hit [CELLS];
  pixel_t        s3_pix [CELLS];
  meta_t         s3_meta;
  logic          s3_valid;
  pixel_t        pick;

  // larger cell index = older in raster order; ties go to the older cell
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        act[i*WIN+j] = (4'(i) < side) && (4'(j) < side);
      end
    end
    for (int p = 0; p < CELLS; p++) begin
      for (int g = 0; g < WIN; g++) begin
        cnt[p][g] = '0;
        for (int j = 0; j < WIN; j++) begin
          if (act[g*WIN+j] && ((key[g*WIN+j] < key[p]) ||
              (key[g*WIN+j] == key[p] && (g*WIN+j) > p))) begin
            cnt[p][g] = cnt[p][g] + GW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
    end
    s2_cnt  <= cnt;
    s2_act  <= act;
    s2_pix  <= pix;
    s2_meta <= meta;
  end

  always_comb begin
    for (int p = 0; p < CELLS; p++) begin
      rank[p] = '0;
      for (int g = 0; g < WIN; g++) begin
        rank[p] = rank[p] + RKW'(s2_cnt[p][g]);
      end
      hit[p] = s2_act[p] && (8'(rank[p]) == 8'(idx));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_hit  <= hit;
    s3_pix  <= s2_pix;
    s3_meta <= s2_meta;
  end

  // exactly one cell hits, so an OR of the masked pixels selects it
  always_comb begin
    pick = '0;
    for (int p = 0; p < CELLS; p++) begin
      if (s3_hit[p]) begin
        pick = pick | s3_pix[p];
      end
    end
  end

  assign res_valid = s3_valid;
  assign res.pix   = pick;
  assign res.meta  = s3_meta;
  assign busy      = 2'(s2_valid) + 2'(s3_valid);

endmodule

[hw/rtl/rlrf_fifo.sv]
// Result queue between the rank pipeline and the output side.
// Depends on rlrf_pkg.
module rlrf_fifo import rlrf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_t      din,
  input  logic         pop,
  output logic         empty,
  output result_t      dout,
  output logic [QAW:0] count
);

  result_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic           do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(do_pop);
    end
  end

endmodule

[hw/rtl/rgb_luminance_rank_filter_core.sv]
// Top level of the RGB luminance rank filter: config registers, front end,
// rank pipeline and result queue. Depends on rlrf_pkg and the rlrf_* modules.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  pixels   | push / full        | pix_red pix_green pix_blue frame_start
//  results  | pop / empty        | out_red out_green out_blue out_row out_col
//           |                    | frame_done
//  config   | cfg_we             | cfg_index cfg_data
//
// One pixel per clock sustained while full is low. A result reaches the queue
// after its pixel passes the line store read, window shift, compare and rank
// sum registers. full is asserted when queued plus in-flight results reach the
// queue depth of 8, so the pipeline itself never stalls. rst is synchronous
// and clears counters, pipeline valids and the queue; line store contents are
// not cleared.
module rgb_luminance_rank_filter_core import rlrf_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int MAX_RADIUS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pix_red,
  input  logic [7:0]  pix_green,
  input  logic [7:0]  pix_blue,
  input  logic        frame_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [9:0]  out_row,
  output logic [9:0]  out_col,
  output logic        frame_done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int WIN = 2 * MAX_RADIUS - 1;
  localparam int CELLS = WIN * WIN;
  localparam int RLIM = (MAX_RADIUS % 2 != 0) ? MAX_RADIUS : MAX_RADIUS - 1;

  logic [2:0]  radius;
  logic [4:0]  rank_index;
  logic [10:0] line_width;
  logic [10:0] frame_height;

  geom_t       geom;
  logic [3:0]  rad;
  logic [5:0]  rr_m1;
  logic [5:0]  idx;
  logic        accept;
  pixel_t      px;

  pixel_t           win_pix [CELLS];
  logic [KEY_W-1:0] win_key [CELLS];
  logic             win_valid;
  meta_t            win_meta;
  logic [1:0]       busy_front, busy_rank;
  logic             res_valid;
  result_t          res, head;
  logic [QAW:0]     q_count;
  logic [QAW+1:0]   load;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= 3'd3;
      rank_index   <= 5'd0;
      line_width   <= 11'd640;
      frame_height <= 11'd480;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_RADIUS:       radius       <= cfg_data[2:0];
        REG_RANK_INDEX:   rank_index   <= cfg_data[4:0];
        REG_LINE_WIDTH:   line_width   <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rad = {1'b0, radius} + 4'(!radius[0]);
    geom.r    = (rad > 4'(RLIM)) ? 4'(RLIM) : rad;
    geom.side = {geom.r[2:0], 1'b0} - 4'd1;
    if (line_width == 11'd0) begin
      geom.w = 11'd1;
    end else if (32'(line_width) > MAX_LINE_WIDTH) begin
      geom.w = 11'(MAX_LINE_WIDTH);
    end else begin
      geom.w = line_width;
    end
    if (frame_height == 11'd0) begin
      geom.h = 11'd1;
    end else if (frame_height > 11'd1024) begin
      geom.h = 11'd1024;
    end else begin
      geom.h = frame_height;
    end
    rr_m1 = 6'(geom.r) * 6'(geom.r) - 6'd1;
    idx   = ({1'b0, rank_index} > rr_m1) ? rr_m1 : {1'b0, rank_index};
  end

  assign load   = (QAW+2)'(q_count) + (QAW+2)'(busy_front) + (QAW+2)'(busy_rank);
  assign full   = (load >= (QAW+2)'(QDEPTH));
  assign accept = push && !full;
  assign px     = '{red: pix_red, green: pix_green, blue: pix_blue};

  rlrf_front #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
    .WIN(WIN)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .px(px),
    .frame_start(frame_start),
    .geom(geom),
    .win_pix(win_pix),
    .win_key(win_key),
    .win_valid(win_valid),
    .win_meta(win_meta),
    .busy(busy_front)
  );

  rlrf_rank #(
    .WIN(WIN)
  ) u_rank (
    .clk(clk),
    .rst(rst),
    .in_valid(win_valid),
    .pix(win_pix),
    .key(win_key),
    .meta(win_meta),
    .side(geom.side),
    .idx(idx),
    .res_valid(res_valid),
    .res(res),
    .busy(busy_rank)
  );

  rlrf_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(res_valid),
    .din(res),
    .pop(pop),
    .empty(empty),
    .dout(head),
    .count(q_count)
  );

  assign out_red    = head.pix.red;
  assign out_green  = head.pix.green;
  assign out_blue   = head.pix.blue;
  assign out_row    = head.meta.row;
  assign out_col    = head.meta.col;
  assign frame_done = head.meta.last;

endmodule

[hw/rtl/rlrf_checker.sv]
// Port-level checks for rgb_luminance_rank_filter_core and its bind.
// Depends only on the top level's ports.
module rlrf_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop
);

  logic [31:0] balance;

  // requests accepted minus results taken
  always_ff @(posedge clk) begin
    if (rst) begin
      balance <= 32'd0;
    end else begin
      balance <= balance + 32'(push && !full) - 32'(pop && !empty);
    end
  end

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not clear after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result dropped without pop");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |-> (balance != 32'd0))
    else $error("more results than requests");

endmodule

bind rgb_luminance_rank_filter_core rlrf_checker u_checker (
  .clk(clk),
  .rst(rst),
  .push(push),
  .full(full),
  .empty(empty),
  .pop(pop)
);
